### hw/rtl/wwwd_pkg.sv
// Shared types and constants for the wake-word window detector.
package wwwd_pkg;

   localparam int HISTORY_DEPTH_DEF = 32;   // default ring depth
   localparam int WIN_W             = 6;    // window_size register width
   localparam int CUT_W             = 8;    // cutoff register width
   localparam int STRIDE_W          = 6;    // features_per_inference width
   localparam int FEAT_W            = 10;   // feature counter width
   localparam int PROB_W            = 8;    // probability width
   localparam int RSP_DATA_W        = 8;    // result word, padded to a byte
   localparam int CSR_ADDR_W        = 4;    // four registers at 4-byte steps
   localparam int CSR_DATA_W        = 32;

   localparam logic [FEAT_W-1:0] FEATURE_LIMIT = 10'd1023;

   localparam logic [WIN_W-1:0]    WINDOW_SIZE_RST = 6'd1;
   localparam logic [CUT_W-1:0]    CUTOFF_RST      = 8'd128;
   localparam logic [STRIDE_W-1:0] STRIDE_RST      = 6'd1;
   localparam logic [FEAT_W-1:0]   WARMUP_RST      = 10'd100;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_WINDOW_SIZE = 2'd0,
      REG_CUTOFF      = 2'd1,
      REG_STRIDE      = 2'd2,
      REG_WARMUP      = 2'd3
   } csr_reg_type;

   // word kind carried on req_tuser
   typedef enum logic {
      CMD_PROBABILITY = 1'b0,
      CMD_CLEAR       = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [WIN_W-1:0]    window_size;
      logic [CUT_W-1:0]    cutoff;
      logic [STRIDE_W-1:0] stride;
      logic [FEAT_W-1:0]   warmup;
   } cfg_type;

endpackage

### hw/rtl/wwwd_csr.sv
// APB-style register file holding the detector configuration.
module wwwd_csr
   import wwwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg_out
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = csr_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg_out    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_WINDOW_SIZE: cfg_in.window_size = csr_pwdata[WIN_W-1:0];
            REG_CUTOFF:      cfg_in.cutoff      = csr_pwdata[CUT_W-1:0];
            REG_STRIDE:      cfg_in.stride      = csr_pwdata[STRIDE_W-1:0];
            REG_WARMUP:      cfg_in.warmup      = csr_pwdata[FEAT_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WINDOW_SIZE: csr_prdata = CSR_DATA_W'(cfg_ff.window_size);
         REG_CUTOFF:      csr_prdata = CSR_DATA_W'(cfg_ff.cutoff);
         REG_STRIDE:      csr_prdata = CSR_DATA_W'(cfg_ff.stride);
         REG_WARMUP:      csr_prdata = CSR_DATA_W'(cfg_ff.warmup);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size <= WINDOW_SIZE_RST;
         cfg_ff.cutoff      <= CUTOFF_RST;
         cfg_ff.stride      <= STRIDE_RST;
         cfg_ff.warmup      <= WARMUP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/wwwd_core.sv
// Probability ring, write position, feature counter and window decision.
module wwwd_core
   import wwwd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg_in,
   input  logic              fire,
   input  cmd_type           cmd,
   input  logic [PROB_W-1:0] prob,
   output logic              detected
);

   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int LEAVES = 1 << PTR_W;
   localparam int EW     = ($clog2(HISTORY_DEPTH + 1) > WIN_W) ?
                           $clog2(HISTORY_DEPTH + 1) : WIN_W;
   localparam int SUM_W  = $clog2(HISTORY_DEPTH * 255 + 1);
   localparam int CMP_W  = CUT_W + EW;

   logic [PROB_W-1:0] history_ff [HISTORY_DEPTH];
   logic [PROB_W-1:0] history_in [HISTORY_DEPTH];
   logic [PROB_W-1:0] hist_wr    [HISTORY_DEPTH];
   logic [PTR_W-1:0]  pos_ff, pos_in;
   logic [FEAT_W-1:0] seen_ff, seen_in;

   logic [EW-1:0]     ws_ext;
   logic [EW-1:0]     eff_win;
   logic [EW-1:0]     pos_inc;
   logic [PTR_W-1:0]  pos_adv;
   logic [FEAT_W:0]   seen_sum;
   logic [FEAT_W-1:0] seen_adv;
   logic [CMP_W-1:0]  threshold;
   logic [SUM_W-1:0]  node [2*LEAVES-1];

   // clamp the window to 1..HISTORY_DEPTH
   assign ws_ext  = EW'(cfg_in.window_size);
   assign eff_win = (ws_ext == '0) ? EW'(1) :
                    (ws_ext > EW'(HISTORY_DEPTH)) ? EW'(HISTORY_DEPTH) : ws_ext;

   // wrap the position whenever the increment leaves the window
   assign pos_inc = EW'(pos_ff) + EW'(1);
   assign pos_adv = (pos_inc >= eff_win) ? '0 : pos_inc[PTR_W-1:0];

   // saturating feature counter
   assign seen_sum = {1'b0, seen_ff} + (FEAT_W+1)'(cfg_in.stride);
   assign seen_adv = (seen_sum > {1'b0, FEATURE_LIMIT}) ? FEATURE_LIMIT
                                                        : seen_sum[FEAT_W-1:0];

   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_wr[i] = (pos_ff == PTR_W'(i)) ? prob : history_ff[i];
      end
   end

   // masked adder tree over the ring with the new word already written
   for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
      if (g < HISTORY_DEPTH) begin : g_used
         assign node[LEAVES-1+g] = (EW'(g) < eff_win) ? SUM_W'(hist_wr[g]) : '0;
      end else begin : g_pad
         assign node[LEAVES-1+g] = '0;
      end
   end

   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      assign node[n] = node[2*n+1] + node[2*n+2];
   end

   assign threshold = CMP_W'(cfg_in.cutoff) * CMP_W'(eff_win);

   assign detected = (cmd == CMD_PROBABILITY) && (seen_adv >= cfg_in.warmup) &&
                     (CMP_W'(node[0]) > threshold);

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         history_in[i] = history_ff[i];
      end
      if (fire) begin
         unique case (cmd)
            CMD_CLEAR: begin
               pos_in  = '0;
               seen_in = '0;
               for (int i = 0; i < HISTORY_DEPTH; i++) begin
                  history_in[i] = '0;
               end
            end
            CMD_PROBABILITY: begin
               pos_in  = pos_adv;
               seen_in = seen_adv;
               for (int i = 0; i < HISTORY_DEPTH; i++) begin
                  history_in[i] = hist_wr[i];
               end
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seen_ff <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= history_in[i];
         end
      end
   end

endmodule

### hw/rtl/wake_word_window_detector.sv
// Top level of the wake-word window detector: stream stages and register file.
//
//  channel | dir | ports                              | word
//  --------+-----+------------------------------------+-------------------------------
//  req     | in  | req_tvalid/tready/tdata/tuser      | tdata: probability; tuser: command
//  rsp     | out | rsp_tvalid/tready/tdata            | tdata: detected (bit 0)
//  csr     | in  | csr_psel/penable/pwrite/paddr/...  | window, cutoff, stride, warmup
//
// One word per cycle sustained while results are taken; each word waits in the input
// register and is decided as it advances to the output register, while the ring,
// position and counter update. The decision path is the masked adder tree over
// HISTORY_DEPTH entries (32 by default) and compare. Synchronous reset clears the ring,
// position, counter and the valid flags of both stages. A stalled result holds in the
// output register; the input stage keeps taking words until it too is full.
module wake_word_window_detector
   import wwwd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PROB_W-1:0]     req_tdata,   // [7:0] probability
   input  logic                  req_tuser,   // [0] command (1 = clear)
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] detected, [7:1] zero
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff, s1_cmd_in;
   logic [PROB_W-1:0] s1_prob_ff, s1_prob_in;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_det_ff, rsp_det_in;

   logic              req_fire;
   logic              advance;
   logic              detected;

   // move the input word into the result stage when the output slot frees up
   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), rsp_det_ff};

   wwwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_out     (cfg)
   );

   wwwd_core #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg_in   (cfg),
      .fire     (advance),
      .cmd      (s1_cmd_ff),
      .prob     (s1_prob_ff),
      .detected (detected)
   );

   always_comb begin
      // hold the input word until it advances, load a new one on accept
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_prob_in  = s1_prob_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = cmd_type'(req_tuser);
         s1_prob_in  = req_tdata;
      end

      // drop the result once taken, capture the decision on advance
      rsp_valid_in = rsp_valid_ff;
      rsp_det_in   = rsp_det_ff;
      if (rsp_valid_ff & rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_det_in   = detected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff  <= s1_cmd_in;
      s1_prob_ff <= s1_prob_in;
      rsp_det_ff <= rsp_det_in;
   end

endmodule

### verif/tb_top.sv
// Testbench for the wake-word window detector: directed and random stream traffic.
module tb_top
   import wwwd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;  // several times the slowest correct run
   localparam int REPORT_LIMIT = 10;      // mismatches printed in full
   localparam int DRAIN_CYCLES = 6;       // pipeline depth plus margin

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PROB_W-1:0]     req_tdata;   // [7:0] probability
   logic                  req_tuser;   // [0] command (1 = clear)
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [0] detected, [7:1] zero
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   wake_word_window_detector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Detector model: registers, probability ring, position and counter
   // ------------------------------------------------------------------
   cfg_type           cfg_model = '{window_size: WINDOW_SIZE_RST, cutoff: CUTOFF_RST,
                                    stride: STRIDE_RST, warmup: WARMUP_RST};
   logic [PROB_W-1:0] prob_ring [HISTORY_DEPTH_DEF];
   int                ring_pos      = 0;
   int                features_seen = 0;

   logic detect_expected [$];   // detected flag of every word still in flight
   int   failures        = 0;
   int   cycle_count     = 0;
   int   send_idle_pct   = 0;   // chance of a gap before each request word
   int   rsp_stall_pct   = 0;   // chance of holding tready low in a cycle

   // Advance the model by one accepted word and return its detected flag.
   function automatic logic decide_word(input cmd_type kind, input logic [PROB_W-1:0] prob);
      int span;
      int advanced;
      int total;
      span = cfg_model.window_size;
      if (span == 0) span = 1;
      if (span > HISTORY_DEPTH_DEF) span = HISTORY_DEPTH_DEF;
      if (kind == CMD_CLEAR) begin
         foreach (prob_ring[i]) prob_ring[i] = '0;
         ring_pos      = 0;
         features_seen = 0;
         return 1'b0;
      end
      prob_ring[ring_pos] = prob;
      // a position left past a shrunken window wraps straight to zero
      ring_pos = (ring_pos + 1 >= span) ? 0 : ring_pos + 1;
      advanced = features_seen + cfg_model.stride;
      features_seen = (advanced > FEATURE_LIMIT) ? FEATURE_LIMIT : advanced;
      if (features_seen < cfg_model.warmup) return 1'b0;
      total = 0;
      for (int i = 0; i < span; i++) total += prob_ring[i];
      return total > cfg_model.cutoff * span;
   endfunction

   function automatic void report_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch @%0d: %s", cycle_count, msg);
   endfunction

   // Clamp center+offset into the probability range.
   function automatic logic [PROB_W-1:0] near(input int center, input int spread);
      int v;
      v = center + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[PROB_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Run guard: count cycles and bail out on a hang
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  detect_expected.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result side: randomize tready at the falling edge, check at the rising
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_result
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (detect_expected.size() == 0) begin
            report_failure($sformatf("result word 0x%02h with nothing outstanding", rsp_tdata));
         end else begin
            want = detect_expected.pop_front();
            if (rsp_tdata[0] !== want)
               report_failure($sformatf("detected: expected %0b, got %0b", want, rsp_tdata[0]));
            if (rsp_tdata[RSP_DATA_W-1:1] !== '0)
               report_failure($sformatf("padding: expected 0, got 0x%02h",
                                        rsp_tdata[RSP_DATA_W-1:1]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Present one word, hold it until accepted, then log its expected result.
   task automatic send_word(input cmd_type kind, input logic [PROB_W-1:0] prob);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         // drop valid and scramble the payload during the gap
         req_tvalid = 1'b0;
         req_tdata  = PROB_W'($urandom_range(255));
         req_tuser  = 1'($urandom_range(1));
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = prob;
      do @(posedge clock); while (!req_tready);
      detect_expected.push_back(decide_word(kind, prob));
   endtask

   // Stop sending and wait until every outstanding result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (detect_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   task automatic csr_access(input csr_reg_type r, input logic write,
                             input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      // setup phase, then access phase; pready is honored though tied high
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = {r, 2'b00};
      csr_pwdata  = write ? value : '0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         case (r)
            REG_WINDOW_SIZE: cfg_model.window_size = value[WIN_W-1:0];
            REG_CUTOFF:      cfg_model.cutoff      = value[CUT_W-1:0];
            REG_STRIDE:      cfg_model.stride      = value[STRIDE_W-1:0];
            REG_WARMUP:      cfg_model.warmup      = value[FEAT_W-1:0];
            default: ;
         endcase
      end else begin
         want = '0;
         case (r)
            REG_WINDOW_SIZE: want[WIN_W-1:0]    = cfg_model.window_size;
            REG_CUTOFF:      want[CUT_W-1:0]    = cfg_model.cutoff;
            REG_STRIDE:      want[STRIDE_W-1:0] = cfg_model.stride;
            REG_WARMUP:      want[FEAT_W-1:0]   = cfg_model.warmup;
            default: ;
         endcase
         if (csr_prdata !== want)
            report_failure($sformatf("readback of %s: expected 0x%0h, got 0x%0h",
                                     r.name(), want, csr_prdata));
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Write all four registers while idle and read each back.
   task automatic apply_config(input int win, input int cut, input int stride, input int warm);
      drain();
      csr_access(REG_WINDOW_SIZE, 1'b1, win);
      csr_access(REG_CUTOFF,      1'b1, cut);
      csr_access(REG_STRIDE,      1'b1, stride);
      csr_access(REG_WARMUP,      1'b1, warm);
      csr_access(REG_WINDOW_SIZE, 1'b0, '0);
      csr_access(REG_CUTOFF,      1'b0, '0);
      csr_access(REG_STRIDE,      1'b0, '0);
      csr_access(REG_WARMUP,      1'b0, '0);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_register_defaults();
      csr_access(REG_WINDOW_SIZE, 1'b0, '0);
      csr_access(REG_CUTOFF,      1'b0, '0);
      csr_access(REG_STRIDE,      1'b0, '0);
      csr_access(REG_WARMUP,      1'b0, '0);
   endtask

   // Clear ignores its probability; a zero stride holds the counter.
   task automatic test_clear_and_stride();
      send_word(CMD_CLEAR, 8'hFF);
      apply_config(1, 0, 0, 1);
      send_word(CMD_PROBABILITY, 8'd200);   // counter stays below warmup
      apply_config(1, 0, 1, 1);
      send_word(CMD_PROBABILITY, 8'd200);   // counter reaches warmup
      send_word(CMD_CLEAR, 8'h00);
   endtask

   // Window zero acts as one, oversize windows clamp to the ring depth,
   // and a position past a shrunken window wraps to zero.
   task automatic test_window_limits();
      apply_config(0, 254, 63, 0);
      send_word(CMD_PROBABILITY, 8'd255);
      send_word(CMD_PROBABILITY, 8'd254);
      send_word(CMD_PROBABILITY, 8'd0);
      apply_config(63, 1, 63, 0);
      send_word(CMD_PROBABILITY, 8'd255);
      send_word(CMD_PROBABILITY, 8'd0);
      send_word(CMD_PROBABILITY, 8'd0);
      apply_config(2, 127, 63, 0);
      send_word(CMD_PROBABILITY, 8'd7);
      send_word(CMD_PROBABILITY, 8'd9);
   endtask

   // Push the feature counter into saturation against the highest warmup.
   task automatic test_counter_saturation();
      apply_config(1, 127, 63, 1023);
      for (int i = 0; i < 10; i++)
         send_word(CMD_PROBABILITY, (i % 2 == 0) ? 8'd255 : 8'd128);
   endtask

   // Random registers per setting, words clustered around a level so that
   // the sum sits near the threshold, with some noise and clears mixed in.
   task automatic test_random_traffic();
      int level;
      int win;
      int cut;
      int stride;
      int warm;
      int roll;
      for (int phase = 0; phase < 3; phase++) begin
         for (int setting = 0; setting < 4; setting++) begin
            level = $urandom_range(255);
            case ($urandom_range(5))
               0: win = 0;
               1: win = 1;
               2: win = HISTORY_DEPTH_DEF;
               3: win = $urandom_range(63, HISTORY_DEPTH_DEF + 1);
               default: win = $urandom_range(HISTORY_DEPTH_DEF, 1);
            endcase
            case ($urandom_range(4))
               0: cut = 0;
               1: cut = 255;
               default: cut = near(level, 12);
            endcase
            case ($urandom_range(4))
               0: stride = 0;
               1: stride = 63;
               default: stride = $urandom_range(16, 1);
            endcase
            case ($urandom_range(4))
               0: warm = 0;
               1: warm = 1023;
               default: warm = $urandom_range(120);
            endcase
            apply_config(win, cut, stride, warm);
            // switch idling only once the pipe is empty
            case (phase)
               0: begin send_idle_pct = 11; rsp_stall_pct = 88; end
               1: begin send_idle_pct = 88; rsp_stall_pct = 11; end
               default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
            endcase
            for (int k = 0; k < 33; k++) begin
               roll = $urandom_range(99);
               if (roll < 4)
                  send_word(CMD_CLEAR, PROB_W'($urandom_range(255)));
               else if (roll < 20)
                  send_word(CMD_PROBABILITY, PROB_W'($urandom_range(255)));
               else
                  send_word(CMD_PROBABILITY, near(level, 20));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      foreach (prob_ring[i]) prob_ring[i] = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      // hold reset, then release it at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_defaults();
      test_clear_and_stride();
      test_window_limits();
      test_counter_saturation();
      test_random_traffic();

      drain();
      if (detect_expected.size() != 0) failures++;
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/wwwd_pkg.sv
hw/rtl/wwwd_csr.sv
hw/rtl/wwwd_core.sv
hw/rtl/wake_word_window_detector.sv
verif/tb_top.sv
